>>> rtl/background_subtract_pixel_top_defines.svh
// Assertion macros for the background subtraction block.
// Used by the top level; expects clk and rst_n in the enclosing scope.
`ifndef BACKGROUND_SUBTRACT_PIXEL_TOP_DEFINES_SVH
`define BACKGROUND_SUBTRACT_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication
`define BSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bsp_pkg.sv
// Package for the background subtraction block: codes, widths and defaults.
// No dependencies; used by every file but bsp_if.sv and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
package bsp_pkg;

  localparam int COORD_W       = 9;
  localparam int PIX_W         = 8;
  localparam int NUM_LANES     = 3;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam int FRAME_W_DEF   = 512;
  localparam int FRAME_H_DEF   = 512;
  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd100;
  localparam logic [PIX_W-1:0] PIX_MAX      = 8'd255;

  typedef enum logic [1:0] {
    KIND_SUB  = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_ADD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_THRESH = 2'd0,
    MODE_CLAMP  = 2'd1,
    MODE_WRAP   = 2'd2,
    MODE_ABS    = 2'd3
  } sub_mode_t;

  typedef enum logic {
    REG_SUB_MODE  = 1'b0,
    REG_THRESHOLD = 1'b1
  } reg_idx_t;

  typedef logic [NUM_LANES-1:0][PIX_W-1:0] rgb_t;

  typedef struct packed {
    sub_mode_t        mode;
    logic [PIX_W-1:0] threshold;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/bsp_if.sv
// Valid/ready channel interfaces for pixel words in and result words out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface bsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [8:0] pix_x;
  logic [8:0] pix_y;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, kind, pix_x, pix_y, in_red, in_green, in_blue,
                  input ready);
  modport sink   (input valid, kind, pix_x, pix_y, in_red, in_green, in_blue,
                  output ready);
endinterface

interface bsp_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] res_x;
  logic [8:0] res_y;
  logic [7:0] res_red;
  logic [7:0] res_green;
  logic [7:0] res_blue;

  modport source (output valid, res_x, res_y, res_red, res_green, res_blue,
                  input ready);
  modport sink   (input valid, res_x, res_y, res_red, res_green, res_blue,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/bsp_cfg.sv
// APB register file: subtraction mode and threshold.
// Depends on bsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsp_cfg import bsp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg
);

  sub_mode_t        mode_r;
  logic [PIX_W-1:0] thresh_r;
  reg_idx_t         idx;
  logic             wr_fire;

  assign pready  = 1'b1;
  assign idx     = reg_idx_t'(paddr[2]);
  assign wr_fire = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_THRESH;
      thresh_r <= THRESH_RESET;
    end else if (wr_fire) begin
      unique case (idx)
        REG_SUB_MODE:  mode_r   <= sub_mode_t'(pwdata[1:0]);
        REG_THRESHOLD: thresh_r <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SUB_MODE:  prdata = {{(CFG_DW-2){1'b0}}, mode_r};
      REG_THRESHOLD: prdata = {{(CFG_DW-PIX_W){1'b0}}, thresh_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.mode      = mode_r;
  assign cfg.threshold = thresh_r;

endmodule
`default_nettype wire

>>> rtl/bsp_store.sv
// Background frame memory with registered read and last-write bypass.
// Depends on bsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsp_store import bsp_pkg::*; #(
  parameter int DEPTH = FRAME_W_DEF * FRAME_H_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire rgb_t          wr_data,
  input  wire logic [AW-1:0] cur_addr,
  output      rgb_t          bg_data
);

  rgb_t            mem [DEPTH];
  rgb_t            rd_data_r;
  logic            last_vld_r;
  logic [AW-1:0]   last_addr_r;
  rgb_t            last_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vld_r <= 1'b0;
    end else if (wr_en) begin
      last_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_addr_r <= wr_addr;
      last_data_r <= wr_data;
    end
  end

  assign bg_data = (last_vld_r && last_addr_r == cur_addr) ? last_data_r : rd_data_r;

endmodule
`default_nettype wire

>>> rtl/bsp_lane.sv
// One colour channel: frame minus background in the selected mode, and wrapped sum.
// Depends on bsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsp_lane import bsp_pkg::*; (
  input  wire logic [PIX_W-1:0] frame_ch,
  input  wire logic [PIX_W-1:0] bg_ch,
  input  wire cfg_t             cfg,
  output      logic [PIX_W-1:0] res_ch,
  output      logic [PIX_W-1:0] sum_ch
);

  logic             ge;
  logic [PIX_W-1:0] diff;
  logic [PIX_W-1:0] absd;

  assign ge     = frame_ch >= bg_ch;
  assign diff   = frame_ch - bg_ch;
  assign absd   = ge ? diff : (bg_ch - frame_ch);
  assign sum_ch = frame_ch + bg_ch;

  always_comb begin
    unique case (cfg.mode)
      MODE_THRESH: res_ch = (absd > cfg.threshold) ? PIX_MAX : '0;
      MODE_CLAMP:  res_ch = ge ? diff : '0;
      MODE_WRAP:   res_ch = diff;
      MODE_ABS:    res_ch = absd;
      default:     res_ch = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/background_subtract_pixel_top.sv
// A subtract word is registered in the memory stage and then the output register.
// One word per clock unless the output stalls; each is one read-modify-write of the
// frame memory, last write bypassed so back-to-back words on one pixel are exact.
// Reset clears the handshake state and loads the mode and threshold registers;
// the frame memory is not cleared and holds nothing defined until a pixel is loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "background_subtract_pixel_top_defines.svh"
module background_subtract_pixel_top import bsp_pkg::*; #(
  parameter int FRAME_WIDTH  = FRAME_W_DEF,
  parameter int FRAME_HEIGHT = FRAME_H_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  bsp_in_if.sink                 in_s,
  bsp_out_if.source              out_m,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t cfg;

  bsp_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // Accept stage
  logic          in_fire;
  logic          in_ready;
  logic          in_inside;
  logic [31:0]   in_addr_full;
  logic [AW-1:0] in_addr;

  assign in_fire      = in_s.valid & in_ready;
  assign in_s.ready   = in_ready;
  assign in_inside    = (32'(in_s.pix_x) < 32'(FRAME_WIDTH)) &&
                        (32'(in_s.pix_y) < 32'(FRAME_HEIGHT));
  assign in_addr_full = 32'(in_s.pix_y) * 32'(FRAME_WIDTH) + 32'(in_s.pix_x);
  assign in_addr      = in_addr_full[AW-1:0];

  // Memory stage
  logic               s1_valid_r;
  kind_t              s1_kind_r;
  logic [COORD_W-1:0] s1_x_r;
  logic [COORD_W-1:0] s1_y_r;
  rgb_t               s1_pix_r;
  logic               s1_inside_r;
  logic [AW-1:0]      s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r   <= kind_t'(in_s.kind);
      s1_x_r      <= in_s.pix_x;
      s1_y_r      <= in_s.pix_y;
      s1_pix_r    <= {in_s.in_red, in_s.in_green, in_s.in_blue};
      s1_inside_r <= in_inside;
      s1_addr_r   <= in_addr;
    end
  end

  logic out_valid_r;
  logic s1_res;
  logic s1_adv;
  logic wr_en;
  rgb_t wr_data;
  rgb_t bg_mem;
  rgb_t bg;
  rgb_t lane_res;
  rgb_t lane_sum;

  assign s1_res   = s1_valid_r && s1_kind_r == KIND_SUB;
  assign s1_adv   = s1_valid_r && (!s1_res || !out_valid_r || out_m.ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    case (s1_kind_r)
      KIND_LOAD: begin
        wr_en   = s1_adv && s1_inside_r;
        wr_data = s1_pix_r;
      end
      KIND_ADD: begin
        wr_en   = s1_adv && s1_inside_r;
        wr_data = lane_sum;
      end
      default: begin
        wr_en   = 1'b0;
        wr_data = lane_sum;
      end
    endcase
  end

  bsp_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk, .rst_n,
    .rd_en    (in_fire),
    .rd_addr  (in_addr),
    .wr_en,
    .wr_addr  (s1_addr_r),
    .wr_data,
    .cur_addr (s1_addr_r),
    .bg_data  (bg_mem)
  );

  assign bg = s1_inside_r ? bg_mem : '0;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    bsp_lane u_lane (
      .frame_ch (s1_pix_r[i]),
      .bg_ch    (bg[i]),
      .cfg,
      .res_ch   (lane_res[i]),
      .sum_ch   (lane_sum[i])
    );
  end

  // Merge lanes into the output register
  logic               out_valid_nxt;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  rgb_t               out_pix_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_m.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res) begin
      out_x_r   <= s1_x_r;
      out_y_r   <= s1_y_r;
      out_pix_r <= lane_res;
    end
  end

  assign out_m.valid     = out_valid_r;
  assign out_m.res_x     = out_x_r;
  assign out_m.res_y     = out_y_r;
  assign out_m.res_red   = out_pix_r[2];
  assign out_m.res_green = out_pix_r[1];
  assign out_m.res_blue  = out_pix_r[0];

  `BSP_ASSERT_NOW(a_ready_when_out_empty, !out_valid_r, in_ready, "input stalled with empty output")
  `BSP_ASSERT_NOW(a_write_inside, wr_en, s1_inside_r && s1_valid_r, "write outside frame")
  `BSP_ASSERT_NEXT(a_sub_emits, s1_adv && s1_res, out_valid_r, "subtract word lost")

endmodule
`default_nettype wire

>>> test/bsp_subtract_checker.sv
// Checker for the background subtraction block: follows the pixel, result and
// register channels, keeps its own background frame and compares each result word.
// Depends on bsp_pkg and the channel interfaces in bsp_if.sv.
`timescale 1ns / 1ps
module bsp_subtract_checker import bsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bsp_in_if                 in_ch,
  bsp_out_if                out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    rgb_t               rgb;
  } diff_word_t;

  sub_mode_t        mode;
  logic [PIX_W-1:0] thresh;
  rgb_t             bg_frame [int];
  diff_word_t       diff_q [$];
  int               errs;

  function automatic logic [PIX_W-1:0] lane_diff(input logic [PIX_W-1:0] f,
                                                 input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] mag;
    mag = (f >= b) ? f - b : b - f;
    case (mode)
      MODE_THRESH: return (mag > thresh) ? PIX_MAX : '0;
      MODE_CLAMP:  return (f >= b) ? f - b : '0;
      MODE_WRAP:   return f - b;
      default:     return mag;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    diff_word_t want_w;
    rgb_t       bg;
    rgb_t       pix;
    rgb_t       sum;
    int         addr;
    logic       in_frame;
    if (!rst_n) begin
      mode   = MODE_THRESH;
      thresh = THRESH_RESET;
      errs   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (diff_q.size() == 0) begin
          errs++;
          $display("%0t: result word expected none got x=%0d y=%0d rgb=%02h%02h%02h", $time,
                   out_ch.res_x, out_ch.res_y, out_ch.res_red, out_ch.res_green,
                   out_ch.res_blue);
        end else begin
          want_w = diff_q.pop_front();
          compare_field("res_x", want_w.x, out_ch.res_x);
          compare_field("res_y", want_w.y, out_ch.res_y);
          compare_field("res_red", want_w.rgb[2], out_ch.res_red);
          compare_field("res_green", want_w.rgb[1], out_ch.res_green);
          compare_field("res_blue", want_w.rgb[0], out_ch.res_blue);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == CFG_AW'(4 * int'(REG_SUB_MODE)))
          mode = sub_mode_t'(pwdata[1:0]);
        else if (paddr == CFG_AW'(4 * int'(REG_THRESHOLD)))
          thresh = pwdata[PIX_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        pix      = {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
        in_frame = (in_ch.pix_x < FRAME_W_DEF) && (in_ch.pix_y < FRAME_H_DEF);
        addr     = int'(in_ch.pix_y) * FRAME_W_DEF + int'(in_ch.pix_x);
        bg       = (in_frame && bg_frame.exists(addr)) ? bg_frame[addr] : '0;
        case (kind_t'(in_ch.kind))
          KIND_SUB: begin
            want_w.x = in_ch.pix_x;
            want_w.y = in_ch.pix_y;
            for (int l = 0; l < NUM_LANES; l++)
              want_w.rgb[l] = lane_diff(pix[l], bg[l]);
            diff_q.push_back(want_w);
          end
          KIND_LOAD: if (in_frame) bg_frame[addr] = pix;
          KIND_ADD: begin
            if (in_frame) begin
              for (int l = 0; l < NUM_LANES; l++)
                sum[l] = pix[l] + bg[l];
              bg_frame[addr] = sum;
            end
          end
          default: ;
        endcase
      end
    end
    mismatches <= errs;
    pending    <= diff_q.size();
  end

endmodule

>>> test/testbench.sv
// Top of the background subtraction test: clock, reset, register writes, pixel
// words and result back-pressure; the verdict comes from bsp_subtract_checker and a stall watchdog.
// Depends on bsp_pkg, bsp_if.sv, the block and the checker.
`timescale 1ns / 1ps
module testbench;
  import bsp_pkg::*;

  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam int ITEMS_PER_PHASE     = 110;
  localparam int NUM_PHASES          = 8;
  localparam int LONG_HOLD           = 200;
  localparam int DRAIN_CYCLES        = 8;
  localparam int STALL_LIMIT         = 3000;
  localparam int FRAME_COLS          = FRAME_W_DEF;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                pending;
  bit                hold_req;
  bit                idle_off;
  bit                loaded [int];
  int                loaded_list [$];

  bsp_in_if  in_ch ();
  bsp_out_if out_ch ();

  background_subtract_pixel_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_ch),
    .out_m   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bsp_subtract_checker diff_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] pick_level();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return '0;
    if (p < 16) return PIX_MAX;
    return PIX_W'($urandom);
  endfunction

  task automatic send_word(input logic [1:0] k, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] r,
                           input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    int gap;
    int addr;
    gap  = idle_off ? 0 : pick_gap();
    addr = int'(y) * FRAME_COLS + int'(x);
    if (k == KIND_LOAD && !loaded.exists(addr)) begin
      loaded[addr] = 1'b1;
      loaded_list.push_back(addr);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= k;
    in_ch.pix_x    <= x;
    in_ch.pix_y    <= y;
    in_ch.in_red   <= r;
    in_ch.in_green <= g;
    in_ch.in_blue  <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random_word();
    int                 p;
    int                 idx;
    int                 addr;
    int                 span;
    logic [1:0]         k;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    p = $urandom_range(0, 99);
    if (loaded_list.size() == 0 || p < 20) begin
      x = COORD_W'($urandom_range(0, FRAME_W_DEF - 1));
      y = COORD_W'($urandom_range(0, FRAME_H_DEF - 1));
    end else begin
      span = (loaded_list.size() > 8) ? 7 : loaded_list.size() - 1;
      if (p < 75) idx = loaded_list.size() - 1 - int'($urandom_range(0, span));
      else idx = $urandom_range(0, loaded_list.size() - 1);
      x = COORD_W'(loaded_list[idx] % FRAME_COLS);
      y = COORD_W'(loaded_list[idx] / FRAME_COLS);
    end
    addr = int'(y) * FRAME_COLS + int'(x);
    p = $urandom_range(0, 99);
    if (!loaded.exists(addr)) k = KIND_LOAD;
    else if (p < 50) k = KIND_SUB;
    else if (p < 65) k = KIND_LOAD;
    else if (p < 90) k = KIND_ADD;
    else k = KIND_SPARE;
    send_word(k, x, y, pick_level(), pick_level(), pick_level());
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_off || $urandom_range(0, 99) < 70) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("background_subtract_pixel_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    cfg_t plan [NUM_PHASES];
    plan[0] = '{MODE_CLAMP, 8'd0};
    plan[1] = '{MODE_WRAP, PIX_W'($urandom_range(1, 254))};
    plan[2] = '{MODE_ABS, PIX_MAX};
    plan[3] = '{MODE_THRESH, 8'd0};
    plan[4] = '{MODE_THRESH, PIX_MAX};
    plan[5] = '{MODE_THRESH, PIX_W'($urandom_range(1, 254))};
    plan[6] = '{MODE_CLAMP, PIX_W'($urandom_range(0, 255))};
    plan[7] = '{MODE_ABS, PIX_W'($urandom_range(0, 255))};

    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = KIND_SUB;
    in_ch.pix_x    = '0;
    in_ch.pix_y    = '0;
    in_ch.in_red   = '0;
    in_ch.in_green = '0;
    in_ch.in_blue  = '0;
    hold_req       = 1'b0;
    idle_off       = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: threshold mode, limit 100
    send_word(KIND_LOAD, 9'd0, 9'd0, 8'h00, 8'h00, 8'h00);
    send_word(KIND_LOAD, 9'd511, 9'd511, 8'hff, 8'hff, 8'hff);
    send_word(KIND_LOAD, 9'd0, 9'd511, 8'h64, 8'h00, 8'hff);
    send_word(KIND_SUB, 9'd0, 9'd0, 8'hff, 8'hff, 8'hff);
    send_word(KIND_SUB, 9'd511, 9'd511, 8'h00, 8'h00, 8'h00);
    send_word(KIND_SUB, 9'd0, 9'd511, 8'hc8, 8'h65, 8'h9b);
    send_word(KIND_ADD, 9'd511, 9'd511, 8'h01, 8'h01, 8'h01);
    send_word(KIND_SUB, 9'd511, 9'd511, 8'h00, 8'h80, 8'hff);
    send_word(KIND_ADD, 9'd0, 9'd0, 8'hff, 8'h80, 8'h7f);
    send_word(KIND_ADD, 9'd0, 9'd0, 8'h02, 8'h80, 8'h81);
    send_word(KIND_SUB, 9'd0, 9'd0, 8'h00, 8'h64, 8'h65);
    send_word(KIND_SPARE, 9'd0, 9'd0, 8'hff, 8'hff, 8'hff);
    send_word(KIND_SUB, 9'd0, 9'd0, 8'h01, 8'h00, 8'h00);
    send_word(KIND_LOAD, 9'd511, 9'd0, 8'h80, 8'h01, 8'hfe);
    send_word(KIND_SUB, 9'd511, 9'd0, 8'h7f, 8'h66, 8'h00);
    send_word(KIND_LOAD, 9'h155, 9'h0aa, 8'ha5, 8'h5a, 8'h3c);
    send_word(KIND_ADD, 9'h155, 9'h0aa, 8'h5a, 8'ha5, 8'hc3);
    send_word(KIND_SUB, 9'h155, 9'h0aa, 8'h00, 8'h00, 8'h00);
    send_word(KIND_LOAD, 9'h0aa, 9'h155, 8'h3d, 8'hc3, 8'h59);
    send_word(KIND_SUB, 9'h0aa, 9'h155, 8'h3c, 8'hc3, 8'h5a);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_reg(REG_SUB_MODE, CFG_DW'(plan[ph].mode));
      write_reg(REG_THRESHOLD, CFG_DW'(plan[ph].threshold));
      idle_off = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 30) begin
          idle_off = 1'b1;
          hold_req = 1'b1;
        end
        send_random_word();
      end
    end
    settle();

    if (mismatches == 0 && pending == 0)
      $display("background_subtract_pixel_top: match");
    else
      $display("background_subtract_pixel_top: mismatch");
    $finish;
  end

endmodule

>>> background_subtract_pixel_top.f
+incdir+rtl
rtl/bsp_pkg.sv
rtl/bsp_if.sv
rtl/bsp_cfg.sv
rtl/bsp_store.sv
rtl/bsp_lane.sv
rtl/background_subtract_pixel_top.sv
test/bsp_subtract_checker.sv
test/testbench.sv
